// ----- src/mart_pkg.sv -----
`timescale 1ns / 1ps
// mart_pkg: widths, codes and reset values shared by the rate tracker
// depends on nothing
package mart_pkg;

  localparam int unsigned HISTORY_DEPTH = 8;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned SAMP_W   = 10;
  localparam int unsigned BLK_W    = 24;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned CAP_W    = 24;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned WLEN_W   = 24;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 24;
  localparam int unsigned SCALE_W  = 20;
  localparam int unsigned PROD_W   = ACC_W + SCALE_W;
  localparam int unsigned TGT_W    = CAP_W + 1;
  localparam int unsigned QBIT_W   = $clog2(CAP_W);

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [SCALE_W-1:0] US_PER_SEC = SCALE_W'(1000000);

  // opcodes carried in tuser
  localparam logic [OP_W-1:0] OP_FRAME   = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_SYNC = 2'd0;
  localparam logic [CFG_AW-1:0] REG_WLEN = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FULL = 2'd2;
  localparam logic [CFG_AW-1:0] REG_MIN  = 2'd3;

  localparam logic              SYNC_RST = 1'b1;
  localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(1000000);
  localparam logic [RATE_W-1:0] FULL_RST = RATE_W'(32768);
  localparam logic [RATE_W-1:0] MIN_RST  = RATE_W'(8192);

  localparam logic [TGT_W-1:0] ROUND_HALF = TGT_W'(256);
  localparam logic [TGT_W-1:0] ROUND_MASK = ~TGT_W'(511);

endpackage

// ----- src/mart_ram.sv -----
`timescale 1ns / 1ps
// mart_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module mart_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/median_audio_rate_tracker.sv -----
`timescale 1ns / 1ps
// median_audio_rate_tracker: top level of the audio rate tracker
// depends on mart_pkg and mart_ram
//
// usage: one input beat per video frame on the s_axis channel. tuser holds the
// opcode (frame done, restart window, clear history and restart), tdata holds
// now_us, frame_samples and frame_blocked_us. each input beat gives exactly one
// output beat on m_axis carrying the current rate, the last capability and the
// rate_changed / evaluated flags.
// the cfg channel writes the four registers; it is always ready and should be
// used only while the tracker is idle.
// a beat that closes no window skips the divider and the median search. closing a window runs
// through the elapsed time, the product and the 24-step restoring divider (skipped when the
// quotient saturates), then the median search over the n stored history entries on the single
// ram read port. one beat is in work at a time.
// s_axis_tready is high whenever the sequencer is idle, even while a result
// waits in the output register; a stalled receiver holds the next result in
// the sequencer until the output register frees up.
// reset: registers take their default values, window and history are empty,
// the rate is 32768 Hz; history ram contents are not cleared.
module median_audio_rate_tracker #(
  parameter int unsigned HISTORY_DEPTH = mart_pkg::HISTORY_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // now_us[47:0], frame_samples[57:48], frame_blocked_us[81:58], zero fill
  input  logic [mart_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode[1:0]
  input  logic [mart_pkg::OP_W-1:0]           s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // rate_hz[17:0], capability[41:18], zero fill
  output logic [mart_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // rate_changed[0], evaluated[1]
  output logic [1:0]                          m_axis_tuser,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mart_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  logic [mart_pkg::CFG_DW-1:0]         cfg_data_i
);

  localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

  localparam int unsigned TW = mart_pkg::TIME_W;
  localparam int unsigned AW = mart_pkg::ACC_W;
  localparam int unsigned PW = mart_pkg::PROD_W;
  localparam int unsigned CPW = mart_pkg::CAP_W;
  localparam int unsigned RW = mart_pkg::RATE_W;
  localparam int unsigned GW = mart_pkg::TGT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ELAP = 4'd1;
  localparam logic [3:0] S_DEN  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_PUSH = 4'd5;
  localparam logic [3:0] S_MLD  = 4'd6;
  localparam logic [3:0] S_MCAP = 4'd7;
  localparam logic [3:0] S_MCMP = 4'd8;
  localparam logic [3:0] S_TGT1 = 4'd9;
  localparam logic [3:0] S_TGT2 = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  // input fields
  logic [mart_pkg::OP_W-1:0]   in_op;
  logic [TW-1:0]               in_now;
  logic [mart_pkg::SAMP_W-1:0] in_samp;
  logic [mart_pkg::BLK_W-1:0]  in_blk;

  assign in_op   = s_axis_tuser;
  assign in_now  = s_axis_tdata[47:0];
  assign in_samp = s_axis_tdata[57:48];
  assign in_blk  = s_axis_tdata[81:58];

  // control and architectural state
  logic [3:0]                  state_q, state_d;
  logic                        sync_q, sync_d;
  logic [mart_pkg::WLEN_W-1:0] wlen_q, wlen_d;
  logic [RW-1:0]               full_q, full_d;
  logic [RW-1:0]               min_q, min_d;
  logic [TW-1:0]               start_q, start_d;
  logic [AW-1:0]               wsamp_q, wsamp_d;
  logic [AW-1:0]               wblk_q, wblk_d;
  logic [CW-1:0]               count_q, count_d;
  logic [HW-1:0]               next_q, next_d;
  logic [RW-1:0]               cur_q, cur_d;
  logic [CPW-1:0]              lcap_q, lcap_d;
  logic                        chg_q, chg_d;
  logic                        eval_q, eval_d;
  logic                        ovld_q, ovld_d;

  // working registers
  logic [TW-1:0]               now_q, now_d;
  logic [TW-1:0]               elap_q, elap_d;
  logic [TW-1:0]               den_q, den_d;
  logic [PW-1:0]               prod_q, prod_d;
  logic [TW-1:0]               rem_q, rem_d;
  logic [CPW-1:0]              quot_q, quot_d;
  logic [mart_pkg::QBIT_W-1:0] qbit_q, qbit_d;
  logic [HW-1:0]               mi_q, mi_d;
  logic [HW-1:0]               mj_q, mj_d;
  logic [CPW-1:0]              cand_q, cand_d;
  logic [CW-1:0]               lt_q, lt_d;
  logic [CW-1:0]               le_q, le_d;
  logic [CPW-1:0]              med_q, med_d;
  logic [GW-1:0]               tgt_q, tgt_d;
  logic [RW-1:0]               orate_q, orate_d;
  logic [CPW-1:0]              ocap_q, ocap_d;
  logic                        ochg_q, ochg_d;
  logic                        oeval_q, oeval_d;

  // history ram
  logic           ram_we;
  logic [HW-1:0]  ram_raddr;
  logic [CPW-1:0] ram_rdata;

  mart_ram #(
    .WIDTH(CPW),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(next_q),
    .wdata_i(quot_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic s_acc;
  logic o_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign o_free        = !ovld_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {6'd0, ocap_q, orate_q};
  assign m_axis_tuser  = {oeval_q, ochg_q};

  // datapath helpers
  logic [AW:0]           samp_sum, blk_sum;
  logic [TW-1:0]         elap_now, wl_eff, half, blk_ext, blk_min, den_raw;
  logic [TW+CPW-1:0]     prod_ext, den_shift;
  logic [TW:0]           r2, den_ext;
  logic                  r_ge;
  logic [CPW-1:0]        prod_lo;
  logic                  m_lt, m_le, m_hit;
  logic [CW-1:0]         lt_n, le_n, med_k;
  logic [CPW-1:0]        t1;
  logic [GW-1:0]         cl1;
  logic [RW-1:0]         cl2, adiff;
  logic                  adopt;

  always_comb begin
    samp_sum  = {1'b0, wsamp_q} + (AW + 1)'(in_samp);
    blk_sum   = {1'b0, wblk_q} + (AW + 1)'(in_blk);
    elap_now  = now_q - start_q;
    wl_eff    = (wlen_q == '0) ? TW'(1) : TW'(wlen_q);
    half      = elap_q >> 1;
    blk_ext   = TW'(wblk_q);
    blk_min   = (blk_ext > half) ? half : blk_ext;
    den_raw   = elap_q - blk_min;
    prod_ext  = (TW + CPW)'(prod_q);
    den_shift = {den_q, CPW'(0)};
    prod_lo   = prod_q[CPW-1:0];
    r2        = {rem_q, prod_lo[qbit_q]};
    den_ext   = {1'b0, den_q};
    r_ge      = (r2 >= den_ext);
    m_lt      = (ram_rdata < cand_q);
    m_le      = (ram_rdata <= cand_q);
    lt_n      = lt_q + CW'(m_lt);
    le_n      = le_q + CW'(m_le);
    med_k     = count_q >> 1;
    m_hit     = (lt_n <= med_k) && (med_k < le_n);
    t1        = med_q - (med_q >> 6);
    cl1       = (tgt_q < GW'(min_q)) ? GW'(min_q) : tgt_q;
    cl2       = (cl1 > GW'(full_q)) ? full_q : cl1[RW-1:0];
    adiff     = (cl2 > cur_q) ? (cl2 - cur_q) : (cur_q - cl2);
    adopt     = ({adiff, 4'd0} > (RW + 4)'(cur_q));
  end

  always_comb begin
    state_d = state_q;
    sync_d  = sync_q;
    wlen_d  = wlen_q;
    full_d  = full_q;
    min_d   = min_q;
    start_d = start_q;
    wsamp_d = wsamp_q;
    wblk_d  = wblk_q;
    count_d = count_q;
    next_d  = next_q;
    cur_d   = cur_q;
    lcap_d  = lcap_q;
    chg_d   = chg_q;
    eval_d  = eval_q;
    ovld_d  = ovld_q;
    now_d   = now_q;
    elap_d  = elap_q;
    den_d   = den_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    qbit_d  = qbit_q;
    mi_d    = mi_q;
    mj_d    = mj_q;
    cand_d  = cand_q;
    lt_d    = lt_q;
    le_d    = le_q;
    med_d   = med_q;
    tgt_d   = tgt_q;
    orate_d = orate_q;
    ocap_d  = ocap_q;
    ochg_d  = ochg_q;
    oeval_d = oeval_q;
    ram_we    = 1'b0;
    ram_raddr = mi_q;

    if (m_axis_tready) begin
      ovld_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        mart_pkg::REG_SYNC: sync_d = cfg_data_i[0];
        mart_pkg::REG_WLEN: wlen_d = cfg_data_i;
        mart_pkg::REG_FULL: full_d = cfg_data_i[RW-1:0];
        mart_pkg::REG_MIN:  min_d  = cfg_data_i[RW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          now_d   = in_now;
          eval_d  = 1'b0;
          chg_d   = 1'b0;
          state_d = S_FIN;
          if (!sync_q) begin
            chg_d = (cur_q != full_q);
            cur_d = full_q;
          end
          priority case (in_op)
            mart_pkg::OP_FRAME: begin
              wsamp_d = samp_sum[AW] ? '1 : samp_sum[AW-1:0];
              wblk_d  = blk_sum[AW] ? '1 : blk_sum[AW-1:0];
              if (sync_q) begin
                state_d = S_ELAP;
              end
            end
            mart_pkg::OP_RESTART: begin
              start_d = in_now;
              wsamp_d = '0;
              wblk_d  = '0;
            end
            mart_pkg::OP_CLEAR: begin
              start_d = in_now;
              wsamp_d = '0;
              wblk_d  = '0;
              count_d = '0;
              next_d  = '0;
            end
            default: ;
          endcase
        end
      end
      S_ELAP: begin
        elap_d  = elap_now;
        state_d = (elap_now < wl_eff) ? S_FIN : S_DEN;
      end
      S_DEN: begin
        den_d   = (den_raw == '0) ? TW'(1) : den_raw;
        prod_d  = PW'(wsamp_q) * PW'(mart_pkg::US_PER_SEC);
        state_d = S_CHK;
      end
      S_CHK: begin
        if (prod_ext >= den_shift) begin
          quot_d  = '1;
          state_d = S_PUSH;
        end else begin
          rem_d   = TW'(prod_q[PW-1:CPW]);
          qbit_d  = mart_pkg::QBIT_W'(CPW - 1);
          quot_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = r_ge ? TW'(r2 - den_ext) : r2[TW-1:0];
        quot_d = {quot_q[CPW-2:0], r_ge};
        qbit_d = qbit_q - 1'b1;
        if (qbit_q == '0) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        ram_we  = 1'b1;
        lcap_d  = quot_q;
        eval_d  = 1'b1;
        start_d = now_q;
        wsamp_d = '0;
        wblk_d  = '0;
        next_d  = (next_q == HW'(HISTORY_DEPTH - 1)) ? '0 : next_q + 1'b1;
        if (count_q != CW'(HISTORY_DEPTH)) begin
          count_d = count_q + 1'b1;
        end
        mi_d    = '0;
        state_d = S_MLD;
      end
      S_MLD: begin
        ram_raddr = mi_q;
        state_d   = S_MCAP;
      end
      S_MCAP: begin
        cand_d    = ram_rdata;
        lt_d      = '0;
        le_d      = '0;
        mj_d      = '0;
        ram_raddr = '0;
        state_d   = S_MCMP;
      end
      S_MCMP: begin
        ram_raddr = mj_q + 1'b1;
        lt_d      = lt_n;
        le_d      = le_n;
        mj_d      = mj_q + 1'b1;
        if (mj_q == HW'(count_q - 1'b1)) begin
          if (m_hit) begin
            med_d   = cand_q;
            state_d = S_TGT1;
          end else begin
            mi_d    = mi_q + 1'b1;
            state_d = S_MLD;
          end
        end
      end
      S_TGT1: begin
        tgt_d   = (GW'(t1) + mart_pkg::ROUND_HALF) & mart_pkg::ROUND_MASK;
        state_d = S_TGT2;
      end
      S_TGT2: begin
        if (adopt) begin
          if (cl2 != cur_q) begin
            chg_d = 1'b1;
          end
          cur_d = cl2;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (o_free) begin
          ovld_d  = 1'b1;
          orate_d = cur_q;
          ocap_d  = lcap_q;
          ochg_d  = chg_q;
          oeval_d = eval_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sync_q  <= mart_pkg::SYNC_RST;
      wlen_q  <= mart_pkg::WLEN_RST;
      full_q  <= mart_pkg::FULL_RST;
      min_q   <= mart_pkg::MIN_RST;
      start_q <= '0;
      wsamp_q <= '0;
      wblk_q  <= '0;
      count_q <= '0;
      next_q  <= '0;
      cur_q   <= mart_pkg::FULL_RST;
      lcap_q  <= '0;
      chg_q   <= 1'b0;
      eval_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sync_q  <= sync_d;
      wlen_q  <= wlen_d;
      full_q  <= full_d;
      min_q   <= min_d;
      start_q <= start_d;
      wsamp_q <= wsamp_d;
      wblk_q  <= wblk_d;
      count_q <= count_d;
      next_q  <= next_d;
      cur_q   <= cur_d;
      lcap_q  <= lcap_d;
      chg_q   <= chg_d;
      eval_q  <= eval_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    elap_q  <= elap_d;
    den_q   <= den_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    qbit_q  <= qbit_d;
    mi_q    <= mi_d;
    mj_q    <= mj_d;
    cand_q  <= cand_d;
    lt_q    <= lt_d;
    le_q    <= le_d;
    med_q   <= med_d;
    tgt_q   <= tgt_d;
    orate_q <= orate_d;
    ocap_q  <= ocap_d;
    ochg_q  <= ochg_d;
    oeval_q <= oeval_d;
  end

endmodule

// ----- tb/median_audio_rate_tracker_test.sv -----
`timescale 1ns / 1ps
// median_audio_rate_tracker_test: self-checking bench for the audio rate tracker
// depends on mart_pkg and median_audio_rate_tracker; a directed table, then random phases with register
// changes; table rows with expected values are checked against them, all other beats against a built-in rate predictor
module median_audio_rate_tracker_test;
  import mart_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX     = '1;
  localparam logic [SAMP_W-1:0] SAMP_MAX     = '1;
  localparam logic [BLK_W-1:0]  BLK_MAX      = '1;
  localparam logic [CAP_W-1:0]  CAP_SAT      = '1;
  localparam logic [ACC_W-1:0]  ACC_SAT      = '1;
  localparam int unsigned       ITEM_TOTAL   = 650;
  localparam int unsigned       SAT_BEATS    = 258;
  localparam int unsigned       TAIL_CYCLES  = 200;
  localparam int unsigned       STALL_LIMIT  = 4000;
  localparam int unsigned       REPORT_LIMIT = 40;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              changed;
    logic              evaluated;
    logic [CAP_W-1:0]  cap;
  } rate_beat_t;

  typedef struct packed {
    bit                is_cfg;
    logic [CFG_AW-1:0] reg_idx;
    logic [CFG_DW-1:0] reg_val;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now;
    logic [SAMP_W-1:0] samples;
    logic [BLK_W-1:0]  blocked;
    bit                typed;
    rate_beat_t        want;
  } script_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = OP_FRAME;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_AW-1:0]     cfg_addr_i    = REG_SYNC;
  logic [CFG_DW-1:0]     cfg_data_i    = '0;

  // predictor state
  logic              reg_sync = SYNC_RST;
  logic [WLEN_W-1:0] reg_wlen = WLEN_RST;
  logic [RATE_W-1:0] reg_full = FULL_RST;
  logic [RATE_W-1:0] reg_min  = MIN_RST;
  logic [TIME_W-1:0] win_start   = '0;
  logic [ACC_W-1:0]  win_samples = '0;
  logic [ACC_W-1:0]  win_blocked = '0;
  int unsigned       cap_hist [HISTORY_DEPTH];
  int unsigned       hist_fill = 0;
  int unsigned       hist_wr   = 0;
  logic [RATE_W-1:0] cur_rate  = FULL_RST;
  logic [CAP_W-1:0]  last_cap  = '0;

  rate_beat_t        pending_beats [$];
  script_row_t       script_rows [$];
  int unsigned       mismatches    = 0;
  int unsigned       beats_checked = 0;
  int unsigned       items_sent    = 0;
  int unsigned       stuck_cycles  = 0;
  int unsigned       rx_hold       = 0;
  logic [7:0]        rx_calm_cnt   = '0;
  bit                rx_calm       = 1'b0;
  bit                tx_calm       = 1'b0;
  logic [TIME_W-1:0] sim_now       = '0;

  median_audio_rate_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = a + b;
    return s[ACC_W] ? ACC_SAT : s[ACC_W-1:0];
  endfunction

  function automatic int unsigned hist_upper_median();
    int unsigned sorted_caps [HISTORY_DEPTH];
    int unsigned v;
    int          i;
    int          j;
    if (hist_fill == 0) return 0;
    for (i = 0; i < int'(hist_fill); i++) begin
      v = cap_hist[i];
      j = i;
      while (j > 0 && sorted_caps[j-1] > v) begin
        sorted_caps[j] = sorted_caps[j-1];
        j--;
      end
      sorted_caps[j] = v;
    end
    return sorted_caps[hist_fill/2];
  endfunction

  task automatic open_window(input logic [TIME_W-1:0] now);
    win_start   = now;
    win_samples = '0;
    win_blocked = '0;
  endtask

  // one beat through the tracker: rate hold, accumulation, window close
  task automatic track_beat(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                            input logic [SAMP_W-1:0] samples,
                            input logic [BLK_W-1:0] blocked, output rate_beat_t res);
    logic [TIME_W-1:0] elapsed;
    longint unsigned   wl;
    longint unsigned   blk;
    longint unsigned   denom;
    longint unsigned   acc64;
    longint unsigned   cap64;
    int unsigned       tgt;
    int unsigned       diff;
    logic              changed;
    logic              evald;
    changed = 1'b0;
    evald   = 1'b0;
    if (!reg_sync) begin
      if (cur_rate != reg_full) changed = 1'b1;
      cur_rate = reg_full;
    end
    case (op)
      OP_FRAME: begin
        win_samples = sat_acc(win_samples, ACC_W'(samples));
        win_blocked = sat_acc(win_blocked, ACC_W'(blocked));
        wl = (reg_wlen == 0) ? 64'd1 : 64'(reg_wlen);
        elapsed = now - win_start;
        if (reg_sync && 64'(elapsed) >= wl) begin
          evald = 1'b1;
          blk = win_blocked;
          if (blk > 64'(elapsed >> 1)) blk = 64'(elapsed >> 1);
          denom = 64'(elapsed) - blk;
          if (denom == 0) denom = 1;
          acc64 = win_samples;
          cap64 = acc64 * 64'd1000000 / denom;
          last_cap = (cap64 > 64'(CAP_SAT)) ? CAP_SAT : cap64[CAP_W-1:0];
          open_window(now);
          cap_hist[hist_wr] = last_cap;
          hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
          if (hist_fill < HISTORY_DEPTH) hist_fill++;
          tgt = hist_upper_median();
          tgt = tgt - (tgt >> 6);
          tgt = (tgt + 32'd256) & ~32'd511;
          if (tgt < reg_min) tgt = reg_min;
          if (tgt > reg_full) tgt = reg_full;
          diff = (tgt > cur_rate) ? tgt - cur_rate : cur_rate - tgt;
          if (diff * 16 > cur_rate) begin
            if (tgt != cur_rate) changed = 1'b1;
            cur_rate = tgt[RATE_W-1:0];
          end
        end
      end
      OP_RESTART: open_window(now);
      OP_CLEAR: begin
        hist_fill = 0;
        hist_wr   = 0;
        open_window(now);
      end
      default: ;
    endcase
    res.rate      = cur_rate;
    res.changed   = changed;
    res.evaluated = evald;
    res.cap       = last_cap;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch on %s at beat %0d: got %0d expected %0d",
               what, beats_checked, got, want);
  endtask

  task automatic check_rate_beat();
    rate_beat_t got;
    rate_beat_t want;
    got.rate      = m_axis_tdata[RATE_W-1:0];
    got.cap       = m_axis_tdata[RATE_W +: CAP_W];
    got.changed   = m_axis_tuser[0];
    got.evaluated = m_axis_tuser[1];
    if (pending_beats.size() == 0) begin
      report_mismatch("beat with nothing pending", got.rate, 0);
      return;
    end
    want = pending_beats.pop_front();
    if (got.rate !== want.rate) report_mismatch("rate_hz", got.rate, want.rate);
    if (got.changed !== want.changed)
      report_mismatch("rate_changed", got.changed, want.changed);
    if (got.evaluated !== want.evaluated)
      report_mismatch("evaluated", got.evaluated, want.evaluated);
    if (got.cap !== want.cap) report_mismatch("capability", got.cap, want.cap);
    beats_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_rate_beat();
  end

  // receiver stalls
  always @(posedge clk_i) begin
    rx_calm_cnt = rx_calm_cnt + 1;
    if (rx_calm_cnt == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold = pick_gap(rx_calm);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("median_audio_rate_tracker_test NOT OK");
      $finish;
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                           input logic [SAMP_W-1:0] samples,
                           input logic [BLK_W-1:0] blocked,
                           input bit typed = 1'b0, input rate_beat_t want = '0);
    int unsigned gap;
    rate_beat_t  pred;
    cfg_valid_i <= 1'b0;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, blocked, samples, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_beat(op, now, samples, blocked, pred);
    pending_beats.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_SYNC: reg_sync = val[0];
      REG_WLEN: reg_wlen = val[WLEN_W-1:0];
      REG_FULL: reg_full = val[RATE_W-1:0];
      REG_MIN:  reg_min  = val[RATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_tracker();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    script_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    script_rows.push_back(row);
  endtask

  task automatic add_beat(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                          input logic [SAMP_W-1:0] samples, input logic [BLK_W-1:0] blocked);
    script_row_t row;
    row         = '0;
    row.op      = op;
    row.now     = now;
    row.samples = samples;
    row.blocked = blocked;
    script_rows.push_back(row);
  endtask

  task automatic add_checked(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                             input logic [SAMP_W-1:0] samples,
                             input logic [BLK_W-1:0] blocked, input logic [RATE_W-1:0] rate,
                             input logic changed, input logic evald,
                             input logic [CAP_W-1:0] cap);
    add_beat(op, now, samples, blocked);
    script_rows[$].typed          = 1'b1;
    script_rows[$].want.rate      = rate;
    script_rows[$].want.changed   = changed;
    script_rows[$].want.evaluated = evald;
    script_rows[$].want.cap       = cap;
  endtask

  task automatic build_script();
    add_checked(OP_FRAME, 0, 0, 0, FULL_RST, 1'b0, 1'b0, 0);
    add_checked(OP_UNUSED, TIME_MAX, SAMP_MAX, BLK_MAX, FULL_RST, 1'b0, 1'b0, 0);
    add_checked(OP_RESTART, 100, 0, 0, FULL_RST, 1'b0, 1'b0, 0);
    add_beat(OP_FRAME, 1000100, SAMP_MAX, 0);
    // zero window length acts as one microsecond
    add_reg(REG_WLEN, 0);
    add_beat(OP_CLEAR, TIME_MAX, 0, 0);
    add_beat(OP_FRAME, TIME_MAX, SAMP_MAX, 0);
    add_checked(OP_FRAME, 0, SAMP_MAX, BLK_MAX, FULL_RST, 1'b1, 1'b1, CAP_SAT);
    // min above full clamps to full
    add_reg(REG_FULL, 8000);
    add_reg(REG_MIN, 131072);
    add_beat(OP_FRAME, 5, 0, 0);
    add_reg(REG_SYNC, 0);
    add_beat(OP_FRAME, 10, 5, 7);
    add_reg(REG_FULL, 131072);
    add_checked(OP_RESTART, 20, 0, 0, 131072, 1'b1, 1'b0, 0);
    add_reg(REG_SYNC, 1);
    add_reg(REG_WLEN, 16000000);
    add_reg(REG_MIN, 1000);
    add_beat(OP_FRAME, 16000019, SAMP_MAX, BLK_MAX);
    add_beat(OP_FRAME, 16000020, SAMP_MAX, BLK_MAX);
    add_beat(OP_CLEAR, 0, 0, 0);
    add_beat(OP_FRAME, TIME_MAX, SAMP_MAX, 0);
  endtask

  task automatic run_script();
    script_row_t row;
    int          i;
    for (i = 0; i < script_rows.size(); i++) begin
      row = script_rows[i];
      if (row.is_cfg) begin
        drain_tracker();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_beat(row.op, row.now, row.samples, row.blocked, row.typed, row.want);
      end
    end
  endtask

  // blocked accumulator runs into saturation, then one huge window exposes it
  task automatic run_blocked_saturation();
    drain_tracker();
    write_reg(REG_SYNC, 1);
    write_reg(REG_WLEN, 16000000);
    send_beat(OP_RESTART, sim_now, 0, 0);
    repeat (SAT_BEATS) send_beat(OP_FRAME, sim_now, SAMP_W'($urandom_range(0, 1023)), BLK_MAX);
    sim_now = sim_now + (48'd1 << 40);
    send_beat(OP_FRAME, sim_now, 0, 0);
  endtask

  task automatic run_random_phase();
    logic              sync_sel;
    logic [WLEN_W-1:0] wl_sel;
    logic [RATE_W-1:0] full_sel;
    logic [RATE_W-1:0] min_sel;
    longint unsigned   wl_eff;
    longint unsigned   base_hz;
    longint unsigned   dt;
    longint unsigned   smp;
    logic [BLK_W-1:0]  blk;
    int unsigned       n_items;
    int unsigned       k;
    int unsigned       r;
    drain_tracker();
    sync_sel = ($urandom_range(0, 9) < 8);
    case ($urandom_range(0, 9))
      0: wl_sel = 1000;
      1: wl_sel = 16000000;
      2: wl_sel = $urandom_range(1000, 200000);
      default: wl_sel = $urandom_range(1000, 30000);
    endcase
    case ($urandom_range(0, 7))
      0: full_sel = 8000;
      1: full_sel = 131072;
      default: full_sel = $urandom_range(8000, 131072);
    endcase
    case ($urandom_range(0, 9))
      0: min_sel = 1000;
      1: min_sel = 131072;
      2: min_sel = $urandom_range(full_sel, 131072);
      default: min_sel = $urandom_range(1000, full_sel);
    endcase
    write_reg(REG_SYNC, sync_sel);
    write_reg(REG_WLEN, wl_sel);
    write_reg(REG_FULL, full_sel);
    write_reg(REG_MIN, min_sel);
    wl_eff  = (wl_sel == 0) ? 1 : wl_sel;
    base_hz = $urandom_range(1000, 140000);
    tx_calm = ($urandom_range(0, 4) == 0);
    n_items = $urandom_range(20, 50);
    if ($urandom_range(0, 9) < 7)
      send_beat($urandom_range(0, 1) ? OP_RESTART : OP_CLEAR, sim_now,
                SAMP_W'($urandom_range(0, 1023)), BLK_W'($urandom));
    for (k = 0; k < n_items && items_sent < ITEM_TOTAL; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_beat(OP_RESTART, sim_now, SAMP_W'($urandom_range(0, 1023)), BLK_W'($urandom));
      end else if (r < 5) begin
        send_beat(OP_CLEAR, sim_now, SAMP_W'($urandom_range(0, 1023)), BLK_W'($urandom));
      end else if (r < 7) begin
        send_beat(OP_UNUSED, rand_time(), SAMP_W'($urandom_range(0, 1023)), BLK_W'($urandom));
      end else if (r < 12) begin
        sim_now = rand_time();
        send_beat(OP_FRAME, sim_now, SAMP_W'($urandom_range(0, 1023)), BLK_W'($urandom));
      end else begin
        dt = $urandom_range(wl_eff / 4, wl_eff / 2 + 1);
        sim_now = sim_now + dt;
        smp = base_hz * dt / 1000000;
        smp = smp * $urandom_range(90, 110) / 100;
        if (smp > SAMP_MAX) smp = SAMP_MAX;
        if ($urandom_range(0, 9) == 0)
          blk = $urandom_range(0, dt * 2);
        else
          blk = $urandom_range(0, dt / 4);
        send_beat(OP_FRAME, sim_now, smp[SAMP_W-1:0], blk);
      end
    end
  endtask

  initial begin
    int unsigned phase_no;
    phase_no = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    build_script();
    run_script();
    sim_now = TIME_MAX - 48'd50000;
    while (items_sent < ITEM_TOTAL) begin
      if (phase_no == 2)
        run_blocked_saturation();
      else
        run_random_phase();
      phase_no++;
    end
    drain_tracker();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_beats.size() == 0)
      $display("median_audio_rate_tracker_test OK");
    else
      $display("median_audio_rate_tracker_test NOT OK");
    $finish;
  end

endmodule
